// ===== design/toq_pkg.sv =====
`timescale 1ns / 1ps

package toq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [19:0] NS_PER_MS = 20'd1000000;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_POP,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_e;

  typedef struct packed {
    logic        valid;
    logic [63:0] deadline;
    logic [15:0] id;
  } entry_t;

  // what a cell hands to its right neighbor
  typedef struct packed {
    entry_t entry;
    logic   gt;
  } nbr_t;

  typedef struct packed {
    cell_op_e    op;
    logic [63:0] deadline;
    logic [15:0] id;
    logic [63:0] now;
  } cell_cmd_t;

endpackage

// ===== design/toq_if.sv =====
`timescale 1ns / 1ps

interface toq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] timer_id;
  logic [31:0] delay_ms;
  logic [63:0] now_ns;

  modport source (output valid, req_type, timer_id, delay_ms, now_ns, input ready);
  modport sink   (input valid, req_type, timer_id, delay_ms, now_ns, output ready);
endinterface

interface toq_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] expired_id;
  logic [63:0] lateness_ns;
  logic        last;

  modport source (output valid, expired_id, lateness_ns, last, input ready);
  modport sink   (input valid, expired_id, lateness_ns, last, output ready);
endinterface

// ===== design/toq_cell.sv =====
`timescale 1ns / 1ps

module toq_cell import toq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  nbr_t      left_i,
  input  entry_t    right_i,
  input  logic      del_i,
  output logic      del_o,
  output nbr_t      out_o,
  output logic      match_o,
  output logic      due_o
);

  entry_t entry_q, entry_d;
  logic   gt_self;

  assign gt_self = entry_q.valid && (entry_q.deadline > cmd_i.deadline);
  assign match_o = entry_q.valid && (entry_q.id == cmd_i.id);
  assign due_o   = entry_q.valid && (entry_q.deadline <= cmd_i.now);
  assign del_o   = del_i | match_o;
  assign out_o.entry = entry_q;
  assign out_o.gt    = gt_self;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      CELL_POP: begin
        entry_d = right_i;
      end
      CELL_DELETE: begin
        if (del_i || match_o) begin
          entry_d = right_i;
        end
      end
      CELL_INSERT: begin
        // larger deadlines move right; new entry lands after equal ones
        if (left_i.gt) begin
          entry_d = left_i.entry;
        end else if (left_i.entry.valid && (!entry_q.valid || gt_self)) begin
          entry_d.valid    = 1'b1;
          entry_d.deadline = cmd_i.deadline;
          entry_d.id       = cmd_i.id;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

// ===== design/one_shot_timer_queue.sv =====
`timescale 1ns / 1ps

// Sorted queue of one-shot timers held in a chain of cells, earliest deadline
// in cell 0. Requests arrive on req_i (tick, add, delete), each carrying the
// current time; expiry transactions leave on res_o with id, lateness and a
// last mark on the final expiry caused by a request.
// req_i.ready is high only while the block is idle. A request is registered
// at acceptance; for a tick or an add, one expiry then pops out of cell 0
// per cycle while the output register is free or res_o is ready (at most
// MAX_RESULTS per request) into the output register. An add then moves on
// to an insert step, every cell shifting in parallel, unless its id is
// already queued or the chain is full. A result is registered and appears
// in the cycle after its pop. If res_o stalls, the output register holds its
// transaction and popping waits; nothing is lost. Reset empties the chain at
// once and drops any pending result.
module one_shot_timer_queue import toq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  toq_req_if.sink   req_i,
  toq_res_if.source res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_INSERT
  } state_e;

  state_e           state_q;
  logic [1:0]       req_q;
  logic [15:0]      id_q;
  logic [63:0]      now_q;
  logic [51:0]      prod_q;
  logic [63:0]      deadline_q;
  logic [CNT_W-1:0] cnt_q;

  logic             out_valid_q;
  logic [15:0]      out_id_q;
  logic [63:0]      out_late_q;
  logic             out_last_q;

  cell_cmd_t        cmd;
  nbr_t             nbr   [TIMER_SLOTS+1];
  logic             del   [TIMER_SLOTS+1];
  logic [TIMER_SLOTS:0]   due;
  logic [TIMER_SLOTS-1:0] match;

  logic             pop_go;
  logic             expire_done;
  logic             found;
  logic             full;
  logic [64:0]      sum;

  assign nbr[0].entry.valid    = 1'b1;
  assign nbr[0].entry.deadline = '0;
  assign nbr[0].entry.id       = '0;
  assign nbr[0].gt             = 1'b0;
  assign del[0]                = 1'b0;
  assign due[TIMER_SLOTS]      = 1'b0;

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    entry_t right;
    if (i == TIMER_SLOTS - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = nbr[i+2].entry;
    end
    toq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (nbr[i]),
      .right_i (right),
      .del_i   (del[i]),
      .del_o   (del[i+1]),
      .out_o   (nbr[i+1]),
      .match_o (match[i]),
      .due_o   (due[i])
    );
  end

  assign found = |match;
  assign full  = nbr[TIMER_SLOTS].entry.valid;
  assign sum   = {1'b0, now_q} + {13'd0, prod_q};
  assign expire_done = !due[0] || (cnt_q == CNT_W'(MAX_RESULTS));

  always_comb begin
    cmd.op       = CELL_HOLD;
    cmd.deadline = deadline_q;
    cmd.id       = id_q;
    cmd.now      = now_q;
    pop_go       = 1'b0;
    case (state_q)
      ST_EXPIRE: begin
        if (req_q == REQ_DELETE) begin
          cmd.op = CELL_DELETE;
        end else if ((req_q == REQ_TICK || req_q == REQ_ADD) && !expire_done &&
                     (!out_valid_q || res_o.ready)) begin
          cmd.op = CELL_POP;
          pop_go = 1'b1;
        end
      end
      ST_INSERT: begin
        if (!found && !full) begin
          cmd.op = CELL_INSERT;
        end
      end
      default: begin
        cmd.op = CELL_HOLD;
      end
    endcase
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.expired_id  = out_id_q;
  assign res_o.lateness_ns = out_late_q;
  assign res_o.last        = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_go) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_q + CNT_W'(1);
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            state_q <= ST_EXPIRE;
            cnt_q   <= '0;
          end
        end
        ST_EXPIRE: begin
          if (req_q != REQ_TICK && req_q != REQ_ADD) begin
            state_q <= ST_IDLE;
          end else if (expire_done) begin
            state_q <= (req_q == REQ_ADD) ? ST_INSERT : ST_IDLE;
          end
        end
        ST_INSERT: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q  <= req_i.req_type;
      id_q   <= req_i.timer_id;
      now_q  <= req_i.now_ns;
      prod_q <= {20'd0, req_i.delay_ms} * {32'd0, NS_PER_MS};
    end
    // saturate on overflow
    if (state_q == ST_EXPIRE) begin
      deadline_q <= sum[64] ? '1 : sum[63:0];
    end
    if (pop_go) begin
      out_id_q   <= nbr[1].entry.id;
      out_late_q <= now_q - nbr[1].entry.deadline;
      out_last_q <= !due[1] || (cnt_q == CNT_W'(MAX_RESULTS - 1));
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import toq_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int EP_NORMAL = 0;
  localparam int EP_FILL   = 1;
  localparam int EP_NOISE  = 2;

  localparam int  ITEMS_TARGET = 220;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  DRAIN_LIMIT  = 20000;
  localparam int  TAIL_CYCLES  = 50;
  localparam int  PRINT_LIMIT  = 40;
  localparam time TIMEOUT_NS   = 5_000_000;

  localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // one request plus, for hand-checked rows, the single expiry it must give
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic [31:0] dly;
    logic [63:0] now;
    logic        typed;
    logic        one_exp;
    logic [15:0] eid;
    logic [63:0] elate;
  } req_row_t;

  typedef struct packed {
    logic [15:0] id;
    logic [63:0] late;
    logic        last;
  } expiry_t;

  localparam int DIR_ROWS = 25;
  localparam req_row_t DIR_TAB [DIR_ROWS] = '{
    '{REQ_TICK,   16'h0000, 32'h0,        64'h0,     1'b1, 1'b0, 16'h0000, 64'h0},
    '{REQ_DELETE, 16'h0005, 32'h0,        64'h0,     1'b1, 1'b0, 16'h0000, 64'h0},
    '{REQ_UNUSED, 16'hFFFF, 32'hFFFFFFFF, T_MAX,     1'b1, 1'b0, 16'h0000, 64'h0},
    // zero delay survives its own add, goes on the next tick
    '{REQ_ADD,    16'h0000, 32'h0,        64'd100,   1'b1, 1'b0, 16'h0000, 64'h0},
    '{REQ_TICK,   16'h0000, 32'h0,        64'd100,   1'b1, 1'b1, 16'h0000, 64'h0},
    // deadline saturates
    '{REQ_ADD,    16'hFFFF, 32'hFFFFFFFF, T_MAX,     1'b1, 1'b0, 16'h0000, 64'h0},
    '{REQ_TICK,   16'h0000, 32'h0,        T_MAX,     1'b1, 1'b1, 16'hFFFF, 64'h0},
    // duplicate id dropped
    '{REQ_ADD,    16'h0001, 32'd1,        64'h0,     1'b1, 1'b0, 16'h0000, 64'h0},
    '{REQ_ADD,    16'h0001, 32'd5,        64'h0,     1'b1, 1'b0, 16'h0000, 64'h0},
    '{REQ_TICK,   16'h0000, 32'h0,        64'd999999, 1'b1, 1'b0, 16'h0000, 64'h0},
    '{REQ_TICK,   16'h0000, 32'h0,        64'd1000000, 1'b1, 1'b1, 16'h0001, 64'h0},
    // tie on deadline keeps insert order
    '{REQ_ADD,    16'h0002, 32'd2,        64'h0,     1'b0, 1'b0, 16'h0000, 64'h0},
    '{REQ_ADD,    16'h0003, 32'd2,        64'h0,     1'b0, 1'b0, 16'h0000, 64'h0},
    '{REQ_ADD,    16'h0004, 32'd1,        64'h0,     1'b0, 1'b0, 16'h0000, 64'h0},
    '{REQ_TICK,   16'h0000, 32'h0,        64'd5000000, 1'b0, 1'b0, 16'h0000, 64'h0},
    // re-add of an id that the same add expires
    '{REQ_ADD,    16'h0007, 32'd1,        64'h0,     1'b0, 1'b0, 16'h0000, 64'h0},
    '{REQ_ADD,    16'h0007, 32'd3,        64'd2000000, 1'b0, 1'b0, 16'h0000, 64'h0},
    '{REQ_DELETE, 16'h0007, 32'h0,        64'h0,     1'b1, 1'b0, 16'h0000, 64'h0},
    '{REQ_DELETE, 16'h0007, 32'h0,        64'h0,     1'b1, 1'b0, 16'h0000, 64'h0},
    '{REQ_TICK,   16'h0000, 32'h0,        T_MAX,     1'b1, 1'b0, 16'h0000, 64'h0},
    '{REQ_ADD,    16'hAAAA, 32'h0,        64'h5555_5555_5555_5555,
      1'b1, 1'b0, 16'h0000, 64'h0},
    '{REQ_ADD,    16'h5555, 32'h0,        64'hAAAA_AAAA_AAAA_AAAA,
      1'b1, 1'b1, 16'hAAAA, 64'h5555_5555_5555_5555},
    '{REQ_TICK,   16'h0000, 32'h0,        T_MAX,
      1'b1, 1'b1, 16'h5555, 64'h5555_5555_5555_5555},
    // largest lateness
    '{REQ_ADD,    16'h0009, 32'h0,        64'h0,     1'b1, 1'b0, 16'h0000, 64'h0},
    '{REQ_TICK,   16'h0000, 32'h0,        T_MAX,     1'b1, 1'b1, 16'h0009, T_MAX}
  };

  logic clk;
  logic rst_n;

  toq_req_if req_if ();
  toq_res_if res_if ();

  one_shot_timer_queue DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .res_o (res_if)
  );

  // predicted timer table, sorted by deadline
  logic [63:0] tq_deadline [TIMER_SLOTS];
  logic [15:0] tq_id       [TIMER_SLOTS];
  int          tq_count;

  expiry_t expiry_q [$];

  int  err_cnt;
  int  n_sent;
  int  burst_left;
  bit  hold_off_req;

  logic        cur_typed;
  logic        cur_one_exp;
  logic [15:0] cur_eid;
  logic [63:0] cur_elate;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("testbench: done, errors");
    $finish;
  end

  task automatic report_mismatch(string what);
    if (err_cnt < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, what);
    err_cnt++;
  endtask

  function automatic void drop_slot(int k);
    int i;
    for (i = k; i < tq_count - 1; i++) begin
      tq_deadline[i] = tq_deadline[i + 1];
      tq_id[i]       = tq_id[i + 1];
    end
    tq_count--;
  endfunction

  // advance the predicted table by one request; queue its expiries if asked
  task automatic apply_request(logic [1:0] kind, logic [15:0] id, logic [31:0] dly,
                               logic [63:0] now, bit push);
    expiry_t     due [MAX_RESULTS];
    int          n;
    int          k;
    int          pos;
    logic [64:0] sum;
    logic [63:0] dl;
    n   = 0;
    pos = -1;
    if (kind == REQ_TICK || kind == REQ_ADD) begin
      while (n < MAX_RESULTS && tq_count > 0 && tq_deadline[0] <= now) begin
        due[n] = '{tq_id[0], now - tq_deadline[0], 1'b0};
        drop_slot(0);
        n++;
      end
      if (n > 0) due[n - 1].last = 1'b1;
      if (push)
        for (k = 0; k < n; k++) expiry_q.push_back(due[k]);
    end
    if (kind == REQ_ADD || kind == REQ_DELETE) begin
      for (k = 0; k < tq_count; k++)
        if (pos < 0 && tq_id[k] == id) pos = k;
    end
    if (kind == REQ_ADD && pos < 0 && tq_count < TIMER_SLOTS) begin
      sum = {1'b0, now} + {33'b0, dly} * {45'b0, NS_PER_MS};
      dl  = sum[64] ? T_MAX : sum[63:0];
      pos = tq_count;
      while (pos > 0 && tq_deadline[pos - 1] > dl) begin
        tq_deadline[pos] = tq_deadline[pos - 1];
        tq_id[pos]       = tq_id[pos - 1];
        pos--;
      end
      tq_deadline[pos] = dl;
      tq_id[pos]       = id;
      tq_count++;
    end else if (kind == REQ_DELETE && pos >= 0) begin
      drop_slot(pos);
    end
  endtask

  // check each expiry transaction, predict on each accepted request
  always @(posedge clk) begin
    expiry_t want;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        if (expiry_q.size() == 0) begin
          report_mismatch($sformatf("unexpected expiry id %h", res_if.expired_id));
        end else begin
          want = expiry_q.pop_front();
          if (res_if.expired_id !== want.id)
            report_mismatch($sformatf("expired_id %h, want %h",
                                      res_if.expired_id, want.id));
          if (res_if.lateness_ns !== want.late)
            report_mismatch($sformatf("lateness_ns %h, want %h (id %h)",
                                      res_if.lateness_ns, want.late, want.id));
          if (res_if.last !== want.last)
            report_mismatch($sformatf("last %b, want %b (id %h)",
                                      res_if.last, want.last, want.id));
        end
      end
      if (req_if.valid && req_if.ready) begin
        apply_request(req_if.req_type, req_if.timer_id, req_if.delay_ms,
                      req_if.now_ns, !cur_typed);
        if (cur_typed && cur_one_exp)
          expiry_q.push_back(expiry_t'{cur_eid, cur_elate, 1'b1});
      end
    end
  end

  function automatic req_row_t mk_row(logic [1:0] kind, logic [15:0] id,
                                      logic [31:0] dly, logic [63:0] now);
    return '{kind, id, dly, now, 1'b0, 1'b0, 16'h0, 64'h0};
  endfunction

  // sender: bursts of back-to-back requests with random gaps between them
  task automatic offer_request(req_row_t r);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= r.kind;
    req_if.timer_id <= r.id;
    req_if.delay_ms <= r.dly;
    req_if.now_ns   <= r.now;
    cur_typed       <= r.typed;
    cur_one_exp     <= r.one_exp;
    cur_eid         <= r.eid;
    cur_elate       <= r.elate;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    n_sent++;
  endtask

  // receiver: ready follows a mode redrawn at random from four, plus one long hold-off
  initial begin
    int cyc;
    int rx_mode;
    int stall_run;
    int i;
    cyc       = 0;
    rx_mode   = 0;
    stall_run = 0;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_if.ready <= 1'b0;
        for (i = 0; i < HOLD_CYCLES; i++) @(negedge clk);
      end
      if (cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= 1'($urandom_range(0, 1));
        2: res_if.ready <= (cyc % 3 != 0);
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            res_if.ready <= 1'b0;
          end else begin
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  initial begin
    int          ep;
    int          ep_kind;
    int          len;
    int          j;
    int          p;
    int          drain;
    bit          high;
    bit          pressure_done;
    logic [63:0] t;
    logic [15:0] id0;
    logic [15:0] step;
    err_cnt         = 0;
    n_sent          = 0;
    burst_left      = 0;
    hold_off_req    = 1'b0;
    pressure_done   = 1'b0;
    tq_count        = 0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_TICK;
    req_if.timer_id = '0;
    req_if.delay_ms = '0;
    req_if.now_ns   = '0;
    cur_typed       = 1'b0;
    cur_one_exp     = 1'b0;
    cur_eid         = '0;
    cur_elate       = '0;
    @(posedge rst_n);

    for (j = 0; j < DIR_ROWS; j++) offer_request(DIR_TAB[j]);

    ep = 0;
    while (n_sent < ITEMS_TARGET) begin
      ep_kind = (ep == 0) ? EP_FILL : $urandom_range(0, 9);
      if (ep_kind > EP_NOISE) ep_kind = (ep_kind < 8) ? EP_NORMAL : ep_kind - 7;
      ep++;
      case (ep_kind)
        EP_FILL: begin
          // empty the table, fill it, overfill it, then expire into a full table
          offer_request(mk_row(REQ_TICK, 16'h0, 32'h0, T_MAX));
          t    = {$urandom_range(0, 32'h0FFF_FFFF), $urandom};
          id0  = 16'($urandom);
          step = 16'($urandom) | 16'h1;
          for (j = 0; j < TIMER_SLOTS; j++)
            offer_request(mk_row(REQ_ADD, id0 + 16'(j) * step,
                                 $urandom_range(1, 20), t));
          offer_request(mk_row(REQ_ADD, id0 + 16'(TIMER_SLOTS) * step, 32'd5, t));
          if (!pressure_done) begin
            hold_off_req  = 1'b1;
            pressure_done = 1'b1;
          end
          offer_request(mk_row(REQ_ADD, id0 + 16'(TIMER_SLOTS + 1) * step, 32'd3,
                               t + 64'($urandom_range(1, 20)) * 64'd1000000));
          offer_request(mk_row(REQ_TICK, 16'h0, 32'h0, T_MAX));
        end
        EP_NOISE: begin
          len = $urandom_range(3, 8);
          for (j = 0; j < len; j++)
            offer_request(mk_row(2'($urandom_range(0, 3)), 16'($urandom), $urandom,
                                 {$urandom, $urandom}));
          offer_request(mk_row(REQ_TICK, 16'h0, 32'h0, T_MAX));
        end
        default: begin
          high = ($urandom_range(0, 4) == 0);
          t    = high ? {32'hFFFF_FFFF, $urandom}
                      : {24'h0, 8'($urandom_range(0, 255)), $urandom};
          len  = $urandom_range(8, 30);
          for (j = 0; j < len; j++) begin
            p = $urandom_range(0, 99);
            if (p < 45) begin
              offer_request(mk_row(REQ_ADD, 16'($urandom_range(0, 23)),
                                   $urandom_range(0, 4), t));
              t = t + 64'($urandom_range(0, 500000));
            end else if (p < 75) begin
              t = t + 64'($urandom_range(0, 3000000));
              offer_request(mk_row(REQ_TICK, 16'($urandom), $urandom, t));
            end else if (p < 90) begin
              offer_request(mk_row(REQ_DELETE, 16'($urandom_range(0, 23)), $urandom,
                                   {$urandom, $urandom}));
            end else if ($urandom_range(0, 2) == 0) begin
              offer_request(mk_row(REQ_UNUSED, 16'($urandom), $urandom,
                                   {$urandom, $urandom}));
            end else begin
              offer_request(mk_row(REQ_DELETE, 16'($urandom), $urandom, t));
            end
          end
          if (high || $urandom_range(0, 1) == 0)
            offer_request(mk_row(REQ_TICK, 16'h0, 32'h0, T_MAX));
        end
      endcase
    end

    @(negedge clk);
    req_if.valid <= 1'b0;

    drain = 0;
    while (expiry_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expiry_q.size() != 0)
      report_mismatch($sformatf("%0d expiries never arrived", expiry_q.size()));

    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
